>>> hw/rtl/mql_pkg.sv
package mql_pkg;

    localparam int DEF_NUM_QUEUES = 10;
    localparam int DEF_POOL_NODES = 256;
    localparam int DEF_KEY_BITS   = 32;

    localparam int QUEUE_INDEX_BITS = 4;
    localparam int ITEM_KEY_BITS    = 32;
    localparam int OUT_KEY_BITS     = 32;
    localparam int STATUS_BITS      = 2;

    localparam int S_TDATA_BITS = 40;
    localparam int S_TUSER_BITS = 1;
    localparam int M_TDATA_BITS = 32;
    localparam int M_TUSER_BITS = 2;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

endpackage

>>> hw/rtl/mql_queue_table.sv
module mql_queue_table #(
    parameter int DEPTH = mql_pkg::DEF_NUM_QUEUES,
    parameter int AW    = 4,
    parameter int DW    = 16
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    // head and tail pointer of each queue
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/mql_node_pool.sv
module mql_node_pool #(
    parameter int DEPTH = mql_pkg::DEF_POOL_NODES,
    parameter int AW    = 8,
    parameter int KW    = mql_pkg::DEF_KEY_BITS
) (
    input  logic          aclk,
    input  logic          key_we,
    input  logic [AW-1:0] key_waddr,
    input  logic [KW-1:0] key_wdata,
    input  logic          next_we,
    input  logic [AW-1:0] next_waddr,
    input  logic [AW-1:0] next_wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [KW-1:0] key_rdata,
    output logic [AW-1:0] next_rdata
);

    logic [KW-1:0] key_mem  [DEPTH];
    logic [AW-1:0] next_mem [DEPTH];
    logic [KW-1:0] key_rdata_reg;
    logic [AW-1:0] next_rdata_reg;

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[key_waddr] <= key_wdata;
        end
        if (next_we) begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (re) begin
            key_rdata_reg  <= key_mem[raddr];
            next_rdata_reg <= next_mem[raddr];
        end
    end

    assign key_rdata  = key_rdata_reg;
    assign next_rdata = next_rdata_reg;

endmodule

>>> hw/rtl/multi_queue_linked_top.sv
// enqueue: S_IDLE takes the word and reads the queue table, S_EXEC registers the result once the output is free
// dequeue: S_IDLE reads the queue table, S_EXEC reads the head node from the node memory, and
//   S_DEQ registers the result; the next word is taken only once the block is back in S_IDLE
// errors (empty queue, full pool, bad index) are reported from S_EXEC
// aresetn low (synchronous) clears queue non-empty bits, free list and fresh counter;
//   pointer and node memories are not cleared and need no clearing pass
module multi_queue_linked_top #(
    parameter int NUM_QUEUES = mql_pkg::DEF_NUM_QUEUES,
    parameter int POOL_NODES = mql_pkg::DEF_POOL_NODES,
    parameter int KEY_BITS   = mql_pkg::DEF_KEY_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mql_pkg::S_TDATA_BITS-1:0] s_tdata,  // queue_index, item_key
    input  logic [mql_pkg::S_TUSER_BITS-1:0] s_tuser,  // mode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mql_pkg::M_TDATA_BITS-1:0] m_tdata,  // out_key
    output logic [mql_pkg::M_TUSER_BITS-1:0] m_tuser   // status
);

    localparam int PW  = $clog2(POOL_NODES);
    localparam int CW  = $clog2(POOL_NODES + 1);
    localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int QIB = mql_pkg::QUEUE_INDEX_BITS;
    localparam int QXW = QW + QIB;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DEQ
    } state_t;

    state_t                   state_reg, state_next;
    logic                     mode_reg, mode_next;
    logic [QW-1:0]            qidx_reg, qidx_next;
    logic                     qvalid_reg, qvalid_next;
    logic [KEY_BITS-1:0]      key_reg, key_next;
    logic [NUM_QUEUES-1:0]    nonempty_reg, nonempty_next;
    logic [PW-1:0]            free_head_reg, free_head_next;
    logic [CW-1:0]            free_count_reg, free_count_next;
    logic [CW-1:0]            fresh_count_reg, fresh_count_next;
    logic                     m_valid_reg, m_valid_next;
    logic [mql_pkg::OUT_KEY_BITS-1:0] out_key_reg, out_key_next;
    mql_pkg::status_t         status_reg, status_next;

    logic                     in_mode;
    logic [QIB-1:0]           in_q;
    logic [mql_pkg::ITEM_KEY_BITS-1:0] in_key;
    logic [QXW-1:0]           in_q_ext;
    logic signed [63:0]       in_key_wide;
    logic signed [KEY_BITS-1:0] rd_key_s;
    logic signed [63:0]       rd_key_wide;

    logic                     qt_we;
    logic [2*PW-1:0]          qt_wdata;
    logic                     qt_re;
    logic [2*PW-1:0]          qt_rdata;
    logic [PW-1:0]            qt_head;
    logic [PW-1:0]            qt_tail;

    logic                     nd_key_we;
    logic [PW-1:0]            nd_key_waddr;
    logic                     nd_next_we;
    logic [PW-1:0]            nd_next_waddr;
    logic [PW-1:0]            nd_next_wdata;
    logic                     nd_re;
    logic [PW-1:0]            nd_raddr;
    logic [KEY_BITS-1:0]      nd_key_rdata;
    logic [PW-1:0]            nd_next_rdata;

    logic                     out_free;
    logic                     q_nonempty;
    logic [PW-1:0]            enq_node;

    assign in_mode     = s_tuser[0];
    assign in_q        = s_tdata[QIB-1:0];
    assign in_key      = s_tdata[QIB+mql_pkg::ITEM_KEY_BITS-1:QIB];
    assign in_q_ext    = {{QW{1'b0}}, in_q};
    assign in_key_wide = 64'(signed'(in_key));

    assign qt_head     = qt_rdata[2*PW-1:PW];
    assign qt_tail     = qt_rdata[PW-1:0];
    assign rd_key_s    = nd_key_rdata;
    assign rd_key_wide = 64'(rd_key_s);

    assign out_free    = !m_valid_reg || m_tready;
    assign q_nonempty  = qvalid_reg && nonempty_reg[qidx_reg];

    mql_queue_table #(
        .DEPTH (NUM_QUEUES),
        .AW    (QW),
        .DW    (2 * PW)
    ) u_queue_table (
        .aclk  (aclk),
        .we    (qt_we),
        .waddr (qidx_reg),
        .wdata (qt_wdata),
        .re    (qt_re),
        .raddr (in_q_ext[QW-1:0]),
        .rdata (qt_rdata)
    );

    mql_node_pool #(
        .DEPTH (POOL_NODES),
        .AW    (PW),
        .KW    (KEY_BITS)
    ) u_node_pool (
        .aclk       (aclk),
        .key_we     (nd_key_we),
        .key_waddr  (nd_key_waddr),
        .key_wdata  (key_reg),
        .next_we    (nd_next_we),
        .next_waddr (nd_next_waddr),
        .next_wdata (nd_next_wdata),
        .re         (nd_re),
        .raddr      (nd_raddr),
        .key_rdata  (nd_key_rdata),
        .next_rdata (nd_next_rdata)
    );

    always_comb begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        qidx_next        = qidx_reg;
        qvalid_next      = qvalid_reg;
        key_next         = key_reg;
        nonempty_next    = nonempty_reg;
        free_head_next   = free_head_reg;
        free_count_next  = free_count_reg;
        fresh_count_next = fresh_count_reg;
        m_valid_next     = m_valid_reg;
        out_key_next     = out_key_reg;
        status_next      = status_reg;

        qt_we         = 1'b0;
        qt_wdata      = '0;
        qt_re         = 1'b0;
        nd_key_we     = 1'b0;
        nd_key_waddr  = '0;
        nd_next_we    = 1'b0;
        nd_next_waddr = '0;
        nd_next_wdata = '0;
        nd_re         = 1'b0;
        nd_raddr      = free_head_reg;
        enq_node      = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    mode_next   = in_mode;
                    qidx_next   = in_q_ext[QW-1:0];
                    qvalid_next = in_q_ext < QXW'(NUM_QUEUES);
                    key_next    = in_key_wide[KEY_BITS-1:0];
                    qt_re       = 1'b1;
                    nd_re       = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                if (mode_reg == mql_pkg::MODE_ENQ) begin
                    if (out_free) begin
                        state_next   = S_IDLE;
                        m_valid_next = 1'b1;
                        out_key_next = '0;
                        if (qvalid_reg && (free_count_reg != '0 ||
                                           fresh_count_reg < CW'(POOL_NODES))) begin
                            status_next = mql_pkg::STATUS_OK;
                            if (free_count_reg != '0) begin
                                enq_node        = free_head_reg;
                                free_head_next  = nd_next_rdata;
                                free_count_next = free_count_reg - 1'b1;
                            end else begin
                                enq_node         = fresh_count_reg[PW-1:0];
                                fresh_count_next = fresh_count_reg + 1'b1;
                            end
                            nd_key_we    = 1'b1;
                            nd_key_waddr = enq_node;
                            // link behind the old tail
                            if (q_nonempty) begin
                                nd_next_we    = 1'b1;
                                nd_next_waddr = qt_tail;
                                nd_next_wdata = enq_node;
                                qt_wdata      = {qt_head, enq_node};
                            end else begin
                                qt_wdata = {enq_node, enq_node};
                            end
                            qt_we                   = 1'b1;
                            nonempty_next[qidx_reg] = 1'b1;
                        end else begin
                            status_next = mql_pkg::STATUS_FULL;
                        end
                    end
                end else begin
                    if (!q_nonempty) begin
                        if (out_free) begin
                            state_next   = S_IDLE;
                            m_valid_next = 1'b1;
                            out_key_next = '0;
                            status_next  = mql_pkg::STATUS_EMPTY;
                        end
                    end else begin
                        nd_re      = 1'b1;
                        nd_raddr   = qt_head;
                        state_next = S_DEQ;
                    end
                end
            end
            S_DEQ: begin
                if (out_free) begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                    out_key_next = rd_key_wide[mql_pkg::OUT_KEY_BITS-1:0];
                    status_next  = mql_pkg::STATUS_OK;
                    if (qt_head == qt_tail) begin
                        nonempty_next[qidx_reg] = 1'b0;
                    end else begin
                        qt_we    = 1'b1;
                        qt_wdata = {nd_next_rdata, qt_tail};
                    end
                    // push freed node on the free list
                    nd_next_we     = 1'b1;
                    nd_next_waddr  = qt_head;
                    nd_next_wdata  = free_head_reg;
                    free_head_next = qt_head;
                    if (free_count_reg < CW'(POOL_NODES)) begin
                        free_count_next = free_count_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            nonempty_reg    <= '0;
            free_head_reg   <= '0;
            free_count_reg  <= '0;
            fresh_count_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            nonempty_reg    <= nonempty_next;
            free_head_reg   <= free_head_next;
            free_count_reg  <= free_count_next;
            fresh_count_reg <= fresh_count_next;
            m_valid_reg     <= m_valid_next;
        end
        mode_reg    <= mode_next;
        qidx_reg    <= qidx_next;
        qvalid_reg  <= qvalid_next;
        key_reg     <= key_next;
        out_key_reg <= out_key_next;
        status_reg  <= status_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_key_reg;
    assign m_tuser  = status_reg;

endmodule

>>> sim/tb_multi_queue_linked_top.sv
module tb_multi_queue_linked_top;

    localparam int NUM_Q     = mql_pkg::DEF_NUM_QUEUES;
    localparam int POOL_SIZE = mql_pkg::DEF_POOL_NODES;
    localparam int QI_BITS   = mql_pkg::QUEUE_INDEX_BITS;

    typedef struct packed {
        logic [mql_pkg::OUT_KEY_BITS-1:0] key;
        mql_pkg::status_t                 status;
    } queue_result_t;

    typedef struct {
        logic                              mode;
        logic [QI_BITS-1:0]                qi;
        logic [mql_pkg::ITEM_KEY_BITS-1:0] key;
        bit                                typed;
        logic [mql_pkg::OUT_KEY_BITS-1:0]  exp_key;
        mql_pkg::status_t                  exp_status;
    } stim_row_t;

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [mql_pkg::S_TDATA_BITS-1:0] s_tdata  = '0;
    logic [mql_pkg::S_TUSER_BITS-1:0] s_tuser  = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [mql_pkg::M_TDATA_BITS-1:0] m_tdata;
    logic [mql_pkg::M_TUSER_BITS-1:0] m_tuser;

    multi_queue_linked_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predicted contents of each queue and number of pool nodes taken
    logic [mql_pkg::OUT_KEY_BITS-1:0] queued_keys [NUM_Q][$];
    int                               nodes_in_use = 0;
    queue_result_t                    pending_results [$];
    int                               fail_count     = 0;
    int                               words_received = 0;
    int                               burst_left     = 0;

    stim_row_t script [22] = '{
        '{mql_pkg::MODE_DEQ, 4'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, mql_pkg::STATUS_EMPTY},
        '{mql_pkg::MODE_DEQ, 4'd15, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, mql_pkg::STATUS_EMPTY},
        '{mql_pkg::MODE_ENQ, 4'd15, 32'h0000_04D2, 1'b1, 32'h0000_0000, mql_pkg::STATUS_FULL},
        '{mql_pkg::MODE_ENQ, 4'd10, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, mql_pkg::STATUS_FULL},
        '{mql_pkg::MODE_DEQ, 4'd10, 32'h0000_0000, 1'b1, 32'h0000_0000, mql_pkg::STATUS_EMPTY},
        '{mql_pkg::MODE_ENQ, 4'd0,  32'h7FFF_FFFF, 1'b1, 32'h0000_0000, mql_pkg::STATUS_OK},
        '{mql_pkg::MODE_ENQ, 4'd0,  32'h8000_0000, 1'b1, 32'h0000_0000, mql_pkg::STATUS_OK},
        '{mql_pkg::MODE_ENQ, 4'd9,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, mql_pkg::STATUS_OK},
        '{mql_pkg::MODE_ENQ, 4'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, mql_pkg::STATUS_OK},
        '{mql_pkg::MODE_ENQ, 4'd5,  32'hA5A5_A5A5, 1'b1, 32'h0000_0000, mql_pkg::STATUS_OK},
        '{mql_pkg::MODE_DEQ, 4'd0,  32'h0000_0000, 1'b1, 32'h7FFF_FFFF, mql_pkg::STATUS_OK},
        '{mql_pkg::MODE_DEQ, 4'd9,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, mql_pkg::STATUS_OK},
        '{mql_pkg::MODE_DEQ, 4'd9,  32'h0000_0000, 1'b1, 32'h0000_0000, mql_pkg::STATUS_EMPTY},
        '{mql_pkg::MODE_ENQ, 4'd0,  32'h5A5A_5A5A, 1'b0, 32'h0000_0000, mql_pkg::STATUS_OK},
        '{mql_pkg::MODE_DEQ, 4'd0,  32'h0000_0000, 1'b1, 32'h8000_0000, mql_pkg::STATUS_OK},
        '{mql_pkg::MODE_DEQ, 4'd0,  32'h1234_5678, 1'b1, 32'h0000_0000, mql_pkg::STATUS_OK},
        '{mql_pkg::MODE_DEQ, 4'd0,  32'h0000_0000, 1'b0, 32'h0000_0000, mql_pkg::STATUS_OK},
        '{mql_pkg::MODE_DEQ, 4'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, mql_pkg::STATUS_EMPTY},
        '{mql_pkg::MODE_DEQ, 4'd5,  32'h0000_0000, 1'b0, 32'h0000_0000, mql_pkg::STATUS_OK},
        '{mql_pkg::MODE_ENQ, 4'd8,  32'h0000_0001, 1'b0, 32'h0000_0000, mql_pkg::STATUS_OK},
        '{mql_pkg::MODE_DEQ, 4'd8,  32'h0000_0000, 1'b0, 32'h0000_0000, mql_pkg::STATUS_OK},
        '{mql_pkg::MODE_ENQ, 4'd7,  32'hC3C3_3C3C, 1'b0, 32'h0000_0000, mql_pkg::STATUS_OK}
    };

    task automatic queue_step(input logic mode, input logic [QI_BITS-1:0] qi,
                              input logic [mql_pkg::ITEM_KEY_BITS-1:0] key,
                              output queue_result_t res);
        res.key    = '0;
        res.status = mql_pkg::STATUS_OK;
        if (mode == mql_pkg::MODE_ENQ) begin
            if (qi >= NUM_Q || nodes_in_use == POOL_SIZE) begin
                res.status = mql_pkg::STATUS_FULL;
            end else begin
                queued_keys[qi].push_back(key);
                nodes_in_use++;
            end
        end else begin
            if (qi >= NUM_Q || queued_keys[qi].size() == 0) begin
                res.status = mql_pkg::STATUS_EMPTY;
            end else begin
                res.key = queued_keys[qi].pop_front();
                nodes_in_use--;
            end
        end
    endtask

    task automatic send_word(input logic mode, input logic [QI_BITS-1:0] qi,
                             input logic [mql_pkg::ITEM_KEY_BITS-1:0] key, input bit typed,
                             input queue_result_t typed_res);
        queue_result_t predicted;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 20);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(mql_pkg::S_TDATA_BITS-QI_BITS-mql_pkg::ITEM_KEY_BITS){1'b0}}, key, qi};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        queue_step(mode, qi, key, predicted);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic send_random(input int deq_pct);
        logic                              mode;
        logic [QI_BITS-1:0]                qi;
        logic [mql_pkg::ITEM_KEY_BITS-1:0] key;
        mode = ($urandom_range(0, 99) < deq_pct) ? mql_pkg::MODE_DEQ : mql_pkg::MODE_ENQ;
        qi   = QI_BITS'(($urandom_range(0, 9) == 0) ? $urandom_range(NUM_Q, 15)
                                                     : $urandom_range(0, NUM_Q-1));
        case ($urandom_range(0, 11))
            0: key = 32'h0000_0000;
            1: key = 32'h7FFF_FFFF;
            2: key = 32'h8000_0000;
            3: key = 32'hFFFF_FFFF;
            default: key = $urandom;
        endcase
        send_word(mode, qi, key, 1'b0, '0);
    endtask

    // receiver: rotating stall pattern plus one long hold-off
    int unsigned rx_cycle       = 0;
    int          hold_left      = 0;
    bit          long_hold_done = 1'b0;

    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (!long_hold_done && words_received >= 40) begin
            long_hold_done <= 1'b1;
            hold_left      <= 300;
            m_tready       <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            case (rx_cycle[7:6])
                2'd0: m_tready <= 1'b1;
                2'd1: m_tready <= rx_cycle[0];
                2'd2: m_tready <= ($urandom_range(0, 9) < 7);
                default: m_tready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    always @(posedge aclk) begin
        queue_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            words_received <= words_received + 1;
            if (pending_results.size() == 0) begin
                $error("unexpected result word: out_key %h status %0d", m_tdata, m_tuser);
                fail_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (m_tdata !== exp_res.key) begin
                    $error("out_key mismatch: expected %h, got %h", exp_res.key, m_tdata);
                    fail_count++;
                end
                if (m_tuser !== exp_res.status) begin
                    $error("status mismatch: expected %0d, got %0d", exp_res.status, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[i]) begin
            send_word(script[i].mode, script[i].qi, script[i].key, script[i].typed,
                      queue_result_t'{key: script[i].exp_key, status: script[i].exp_status});
        end

        // mixed traffic
        repeat (200) send_random(50);

        // drain completely, then exhaust the pool
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        while (nodes_in_use < POOL_SIZE) begin
            send_word(mql_pkg::MODE_ENQ, QI_BITS'($urandom_range(0, NUM_Q-1)), $urandom,
                      1'b0, '0);
        end
        repeat (12) send_random(0);

        // mostly dequeues, hitting full and empty along the way
        repeat (200) send_random(70);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
